// ===== rtl/ssgk_pkg.sv =====
// Shared constants and types for the stable key sorter and grouper.
// No dependencies; used by ssgk_sort_seq and stable_sort_and_group_keys_unit.
package ssgk_pkg;

    // Default sizing of the store and the kept key bits.
    localparam int DEF_MAX_ITEMS = 64;
    localparam int DEF_KEY_WIDTH = 64;

    // Fixed port widths of the input and result words.
    localparam int IN_KEY_W   = 64;
    localparam int ORIG_IDX_W = 6;
    localparam int GROUP_W    = 7;

    // Control from the sequencer to the result stage for one result word.
    typedef struct packed {
        logic fire;      // load the result register from the read data
        logic first;     // first element of the sorted run
        logic last_res;  // final element of the sorted run
    } t_emit;

endpackage

// ===== rtl/ssgk_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssgk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ssgk_sort_seq.sv =====
// Sequencer for loading, stable bottom-up merge passes and result read-out.
// Depends on ssgk_pkg; drives the ports of the entry RAM (ssgk_ram).
module ssgk_sort_seq #(
    parameter int MAX_ITEMS = ssgk_pkg::DEF_MAX_ITEMS,
    parameter int KEY_WIDTH = ssgk_pkg::DEF_KEY_WIDTH,
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int EW    = KEY_WIDTH + IDX_W,
    localparam int AW    = IDX_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input word handshake.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic                 i_last,
    // Entry RAM.
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [EW-1:0]        o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    input  logic [EW-1:0]        i_rdata,
    // Result stage.
    input  logic                 i_out_free,
    output ssgk_pkg::t_emit      o_emit
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int POS_W = CNT_W + 1;
    localparam int SUM_W = POS_W + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN_INIT,
        S_HEAD,
        S_MERGE,
        S_FILL,
        S_OREAD,
        S_OCAP
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [POS_W-1:0]     r_w, n_w;
    logic [POS_W-1:0]     r_lo, n_lo;
    logic [POS_W-1:0]     r_mid, n_mid;
    logic [POS_W-1:0]     r_hi, n_hi;
    logic [POS_W-1:0]     r_a, n_a;
    logic [POS_W-1:0]     r_b, n_b;
    logic [POS_W-1:0]     r_t, n_t;
    logic [POS_W-1:0]     r_i, n_i;
    logic                 r_src, n_src;
    logic                 r_fill_b, n_fill_b;
    logic [KEY_WIDTH-1:0] r_key_a, n_key_a;
    logic [KEY_WIDTH-1:0] r_key_b, n_key_b;
    logic [IDX_W-1:0]     r_idx_a, n_idx_a;
    logic [IDX_W-1:0]     r_idx_b, n_idx_b;

    logic [POS_W-1:0]     n_ext;
    logic [CNT_W-1:0]     count_inc;
    logic [SUM_W-1:0]     sum_lo_w;
    logic [SUM_W-1:0]     sum_lo_2w;
    logic [SUM_W-1:0]     w_dbl;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [IDX_W-1:0]     rd_idx;
    logic                 take_a;
    logic [POS_W-1:0]     a_nx;
    logic [POS_W-1:0]     b_nx;
    logic [POS_W-1:0]     t_nx;

    assign n_ext     = POS_W'(r_n);
    assign count_inc = r_count + CNT_W'(1);
    assign sum_lo_w  = SUM_W'(r_lo) + SUM_W'(r_w);
    assign sum_lo_2w = SUM_W'(r_lo) + (SUM_W'(r_w) << 1);
    assign w_dbl     = SUM_W'(r_w) << 1;
    assign rd_key    = i_rdata[EW-1:IDX_W];
    assign rd_idx    = i_rdata[IDX_W-1:0];

    // Stable choice: the left run wins ties.
    assign take_a = (r_a < r_mid) && ((r_b >= r_hi) || (r_key_a <= r_key_b));
    assign a_nx   = r_a + POS_W'(1);
    assign b_nx   = r_b + POS_W'(1);
    assign t_nx   = r_t + POS_W'(1);

    assign o_stall = (r_state != S_LOAD);

    // Next-state and RAM control.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_w      = r_w;
        n_lo     = r_lo;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_a      = r_a;
        n_b      = r_b;
        n_t      = r_t;
        n_i      = r_i;
        n_src    = r_src;
        n_fill_b = r_fill_b;
        n_key_a  = r_key_a;
        n_key_b  = r_key_b;
        n_idx_a  = r_idx_a;
        n_idx_b  = r_idx_b;
        o_we     = 1'b0;
        o_waddr  = {~r_src, r_t[IDX_W-1:0]};
        o_wdata  = take_a ? {r_key_a, r_idx_a} : {r_key_b, r_idx_b};
        o_re     = 1'b0;
        o_raddr  = {r_src, r_a[IDX_W-1:0]};
        o_emit   = '0;

        unique case (r_state)
            // Store each word with its arrival index in bank zero.
            S_LOAD: begin
                o_waddr = {1'b0, r_count[IDX_W-1:0]};
                o_wdata = {i_key, r_count[IDX_W-1:0]};
                if (i_valid) begin
                    o_we    = 1'b1;
                    n_count = count_inc;
                    if (i_last || (count_inc == CNT_W'(MAX_ITEMS))) begin
                        n_count = '0;
                        n_n     = count_inc;
                        n_src   = 1'b0;
                        n_w     = POS_W'(1);
                        n_lo    = '0;
                        n_i     = '0;
                        if (count_inc == CNT_W'(1)) begin
                            n_state = S_OREAD;
                        end else begin
                            n_state = S_RUN_INIT;
                        end
                    end
                end
            end

            // Set up the bounds of one pair of runs and fetch the left head.
            S_RUN_INIT: begin
                n_mid = (sum_lo_w < SUM_W'(n_ext)) ? POS_W'(sum_lo_w) : n_ext;
                n_hi  = (sum_lo_2w < SUM_W'(n_ext)) ? POS_W'(sum_lo_2w) : n_ext;
                n_a   = r_lo;
                n_b   = n_mid;
                n_t   = r_lo;
                o_re  = 1'b1;
                o_raddr = {r_src, r_lo[IDX_W-1:0]};
                n_state = S_HEAD;
            end

            // Capture the left head; fetch the right head if that run exists.
            S_HEAD: begin
                n_key_a = rd_key;
                n_idx_a = rd_idx;
                if (r_mid < r_hi) begin
                    o_re     = 1'b1;
                    o_raddr  = {r_src, r_b[IDX_W-1:0]};
                    n_fill_b = 1'b1;
                    n_state  = S_FILL;
                end else begin
                    n_state = S_MERGE;
                end
            end

            // Move one entry to the other bank and refill the head it came from.
            S_MERGE: begin
                o_we = 1'b1;
                n_t  = t_nx;
                if (take_a) begin
                    n_a      = a_nx;
                    n_fill_b = 1'b0;
                    o_raddr  = {r_src, a_nx[IDX_W-1:0]};
                end else begin
                    n_b      = b_nx;
                    n_fill_b = 1'b1;
                    o_raddr  = {r_src, b_nx[IDX_W-1:0]};
                end
                if (t_nx == r_hi) begin
                    if (sum_lo_2w < SUM_W'(n_ext)) begin
                        n_lo    = POS_W'(sum_lo_2w);
                        n_state = S_RUN_INIT;
                    end else begin
                        // Pass done: the written bank becomes the source.
                        n_src = ~r_src;
                        if (w_dbl < SUM_W'(n_ext)) begin
                            n_w     = POS_W'(w_dbl);
                            n_lo    = '0;
                            n_state = S_RUN_INIT;
                        end else begin
                            n_i     = '0;
                            n_state = S_OREAD;
                        end
                    end
                end else if (take_a ? (a_nx < r_mid) : (b_nx < r_hi)) begin
                    o_re    = 1'b1;
                    n_state = S_FILL;
                end else begin
                    n_state = S_MERGE;
                end
            end

            // Take the refilled head from the RAM.
            S_FILL: begin
                if (r_fill_b) begin
                    n_key_b = rd_key;
                    n_idx_b = rd_idx;
                end else begin
                    n_key_a = rd_key;
                    n_idx_a = rd_idx;
                end
                n_state = S_MERGE;
            end

            // Read the next entry of the sorted bank.
            S_OREAD: begin
                o_re    = 1'b1;
                o_raddr = {r_src, r_i[IDX_W-1:0]};
                n_state = S_OCAP;
            end

            // Hand the entry to the result stage once its register is free.
            S_OCAP: begin
                if (i_out_free) begin
                    o_emit.fire     = 1'b1;
                    o_emit.first    = (r_i == '0);
                    o_emit.last_res = ((r_i + POS_W'(1)) == n_ext);
                    n_i             = r_i + POS_W'(1);
                    if ((r_i + POS_W'(1)) == n_ext) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_OREAD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_n      <= n_n;
        r_w      <= n_w;
        r_lo     <= n_lo;
        r_mid    <= n_mid;
        r_hi     <= n_hi;
        r_a      <= n_a;
        r_b      <= n_b;
        r_t      <= n_t;
        r_i      <= n_i;
        r_src    <= n_src;
        r_fill_b <= n_fill_b;
        r_key_a  <= n_key_a;
        r_key_b  <= n_key_b;
        r_idx_a  <= n_idx_a;
        r_idx_b  <= n_idx_b;
    end

endmodule

// ===== rtl/stable_sort_and_group_keys_unit.sv =====
// Stable key sorter and grouper. Load: one word per cycle, then the block stalls.
// Sort: stable bottom-up merge passes, each merging pairs of runs through the one RAM port.
// Read-out: each result word is read from the RAM, then loaded into the result register
// once it is free. One set is loaded, sorted and read out before the next set is taken.
// Reset (synchronous, active low) empties the store; RAM contents are not cleared.
// Depends on ssgk_pkg, ssgk_ram and ssgk_sort_seq.
module stable_sort_and_group_keys_unit #(
    parameter int MAX_ITEMS = ssgk_pkg::DEF_MAX_ITEMS,
    parameter int KEY_WIDTH = ssgk_pkg::DEF_KEY_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ssgk_pkg::IN_KEY_W-1:0]   i_key,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ssgk_pkg::ORIG_IDX_W-1:0] o_original_index,
    output logic [ssgk_pkg::GROUP_W-1:0]    o_group_id,
    output logic [ssgk_pkg::GROUP_W-1:0]    o_group_count,
    output logic                            o_final_res
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int EW    = KEY_WIDTH + IDX_W;
    localparam int AW    = IDX_W + 1;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;
    ssgk_pkg::t_emit      emit;
    logic                 out_free;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [CNT_W-1:0]     grp;

    logic                 r_valid;
    logic [KEY_WIDTH-1:0] r_prev;
    logic [CNT_W-1:0]     r_group;
    logic [ssgk_pkg::ORIG_IDX_W-1:0] r_idx;
    logic [ssgk_pkg::GROUP_W-1:0]    r_gid;
    logic [ssgk_pkg::GROUP_W-1:0]    r_gcnt;
    logic                 r_final;

    // Both index banks with their keys share one RAM; the bank is the top address bit.
    ssgk_ram #(
        .WIDTH (EW),
        .DEPTH (1 << AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ssgk_sort_seq #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_key      (i_key[KEY_WIDTH-1:0]),
        .i_last     (i_last),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    // The result register can take a new word when empty or being drained.
    assign out_free = !r_valid || !i_stall;
    assign rd_key   = ram_rdata[EW-1:IDX_W];

    // Dense group numbering: a new group opens whenever the key changes.
    always_comb begin
        if (emit.first) begin
            grp = CNT_W'(1);
        end else if (rd_key != r_prev) begin
            grp = r_group + CNT_W'(1);
        end else begin
            grp = r_group;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit.fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (emit.fire) begin
            r_prev  <= rd_key;
            r_group <= grp;
            r_idx   <= ssgk_pkg::ORIG_IDX_W'(ram_rdata[IDX_W-1:0]);
            r_gid   <= ssgk_pkg::GROUP_W'(grp);
            r_gcnt  <= emit.last_res ? ssgk_pkg::GROUP_W'(grp) : '0;
            r_final <= emit.last_res;
        end
    end

    assign o_valid          = r_valid;
    assign o_original_index = r_idx;
    assign o_group_id       = r_gid;
    assign o_group_count    = r_gcnt;
    assign o_final_res      = r_final;

endmodule
